>>> design/srrw_pkg.sv
// Shared types and codes for the selective-repeat receive window.
// It stands alone and is imported by selective_repeat_receive_window.
package srrw_pkg;

	// Controller states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_STORE = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;
	localparam logic [1:0] S_READ  = 2'd3;

	// Result kinds
	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	// Configuration register indexes
	localparam logic REG_WINDOW_SIZE = 1'b0;
	localparam logic REG_START_SEQ   = 1'b1;

	localparam logic [4:0] WINDOW_SIZE_RESET = 5'd16;

	// One stored frame in the slot memory.
	typedef struct packed {
		logic [63:0] payload;
		logic [3:0]  bytes;
		logic        end_flag;
	} slot_entry_t;

endpackage

>>> design/selective_repeat_receive_window.sv
// Selective-repeat receive window: slot memory, valid bits and the delivery sequencer.
// Depends on srrw_pkg for state codes, result kinds, register indexes and the slot type.

// A frame is taken when start is high and busy is low. The block then stays busy
// while it stores the frame and delivers the in-order run at the head of the window.
// A frame that delivers nothing goes through the store and check states to its
// acknowledgement word. A run of delivered frames adds the read state, which gives
// the words one after another, then a return to the head check; the head slots
// are read one per cycle from the slot memory's registered read port. Each result
// word is shown for exactly one cycle with result_valid high and cannot be stalled;
// the acknowledgement, marked by last_of_run, is always the final word of a frame and
// busy is low in the cycle that shows it. Writing start_seq restarts the connection:
// the expected sequence is loaded, the head returns to slot zero and all slot valid
// bits clear at once. Configuration may only be written while the block is idle.
module selective_repeat_receive_window
	import srrw_pkg::*;
#(
	parameter int WINDOW_DEPTH  = 16,
	parameter int PAYLOAD_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        start,
	output logic        busy,
	input  logic [31:0] frame_seq,
	input  logic [63:0] frame_payload,
	input  logic [3:0]  frame_bytes,
	input  logic        frame_end,

	output logic        result_valid,
	output logic        kind,
	output logic [31:0] result_seq,
	output logic [63:0] delivered_data,
	output logic [3:0]  delivered_bytes,
	output logic        message_end,
	output logic        last_of_run
);

	localparam int IdxW = $clog2(WINDOW_DEPTH);
	localparam int SpanW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [63:0] PayloadMask = (PAYLOAD_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * PAYLOAD_BYTES)) - 64'd1);
	localparam logic [3:0] MaxBytes = 4'(PAYLOAD_BYTES);
	localparam logic [IdxW:0] DepthW = (IdxW + 1)'(WINDOW_DEPTH);
	localparam logic [IdxW-1:0] LastSlot = IdxW'(WINDOW_DEPTH - 1);

	logic [1:0]              state_q;
	logic [4:0]              window_size_q;
	logic [31:0]             next_exp_q;
	logic [IdxW-1:0]         head_q;
	logic [WINDOW_DEPTH-1:0] slot_valid_q;

	logic [31:0]  seq_q;
	slot_entry_t  frame_q;

	slot_entry_t  mem [WINDOW_DEPTH];
	slot_entry_t  rd_q;

	logic         res_valid_q;
	logic         res_kind_q;
	logic [31:0]  res_seq_q;
	logic [63:0]  res_data_q;
	logic [3:0]   res_bytes_q;
	logic         res_end_q;
	logic         res_last_q;

	logic [SpanW-1:0] span;
	logic [31:0]      seq_delta;
	logic             in_window;
	logic [IdxW:0]    slot_sum;
	logic [IdxW-1:0]  store_slot;
	logic [IdxW-1:0]  head_nxt;
	logic             accept;
	logic             mem_we;
	logic             rd_en;
	logic [IdxW-1:0]  rd_addr;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);

	always_comb begin
		if (32'(window_size_q) > 32'(WINDOW_DEPTH)) begin
			span = SpanW'(WINDOW_DEPTH);
		end else begin
			span = SpanW'(window_size_q);
		end
	end

	// Distance from the next expected number, modulo 2^32.
	assign seq_delta = seq_q - next_exp_q;
	assign in_window = (seq_delta < 32'(span));
	assign slot_sum = {1'b0, head_q} + {1'b0, seq_delta[IdxW-1:0]};
	assign store_slot = (slot_sum >= DepthW) ? IdxW'(slot_sum - DepthW) : slot_sum[IdxW-1:0];
	assign head_nxt = (head_q == LastSlot) ? '0 : head_q + 1'b1;

	assign mem_we = (state_q == S_STORE) && in_window;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = head_q;
		case (state_q)
			S_CHECK: begin
				rd_en = slot_valid_q[head_q];
				rd_addr = head_q;
			end
			S_READ: begin
				rd_en = slot_valid_q[head_nxt];
				rd_addr = head_nxt;
			end
			default: begin
				rd_en = 1'b0;
				rd_addr = head_q;
			end
		endcase
	end

	// Slot memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[store_slot] <= frame_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// The frame word is captured on acceptance, already trimmed to the built width.
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= frame_seq;
			frame_q.payload <= frame_payload & PayloadMask;
			frame_q.bytes <= (frame_bytes > MaxBytes) ? MaxBytes : frame_bytes;
			frame_q.end_flag <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			window_size_q <= WINDOW_SIZE_RESET;
			next_exp_q <= '0;
			head_q <= '0;
			slot_valid_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_wr) begin
				case (cfg_index)
					REG_WINDOW_SIZE: begin
						window_size_q <= cfg_data[4:0];
					end
					REG_START_SEQ: begin
						next_exp_q <= cfg_data;
						head_q <= '0;
						slot_valid_q <= '0;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					if (in_window) begin
						slot_valid_q[store_slot] <= 1'b1;
					end
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (slot_valid_q[head_q]) begin
						state_q <= S_READ;
					end else begin
						res_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					// The head word is in rd_q; retire it and chain to the next slot.
					res_valid_q <= 1'b1;
					slot_valid_q[head_q] <= 1'b0;
					head_q <= head_nxt;
					next_exp_q <= next_exp_q + 32'd1;
					if (!slot_valid_q[head_nxt]) begin
						state_q <= S_CHECK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result word payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			res_kind_q <= KIND_DELIVER;
			res_seq_q <= next_exp_q;
			res_data_q <= rd_q.payload;
			res_bytes_q <= rd_q.bytes;
			res_end_q <= rd_q.end_flag;
			res_last_q <= 1'b0;
		end else if (state_q == S_CHECK) begin
			res_kind_q <= KIND_ACK;
			res_seq_q <= seq_q;
			res_data_q <= '0;
			res_bytes_q <= '0;
			res_end_q <= 1'b0;
			res_last_q <= 1'b1;
		end
	end

	assign result_valid = res_valid_q;
	assign kind = res_kind_q;
	assign result_seq = res_seq_q;
	assign delivered_data = res_data_q;
	assign delivered_bytes = res_bytes_q;
	assign message_end = res_end_q;
	assign last_of_run = res_last_q;

`ifndef NO_ASSERTIONS
	// The acknowledgement closes the run, so the block is idle when it shows.
	a_ack_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_last_q) |-> (state_q == S_IDLE))
		else $error("acknowledgement shown while busy");

	// A delivered word carries the sequence the window just slid past.
	a_deliver_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_last_q) |-> (res_seq_q == next_exp_q - 32'd1))
		else $error("delivered sequence out of step with window");

	// The head slot being read out must hold a stored frame.
	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> slot_valid_q[head_q])
		else $error("reading an empty head slot");

	// An accepted frame always goes to the store step next.
	a_accept_store: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_STORE))
		else $error("accepted frame not stored");
`endif

endmodule

>>> test/srrw_window_checker.sv
// Checker for the selective-repeat receive window: it watches register writes,
// accepted frames and result words, predicts every word and compares them in order.
// Depends on srrw_pkg for result kinds, register indexes and the slot entry type.
module srrw_window_checker
	import srrw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] frame_seq,
	input  logic [63:0] frame_payload,
	input  logic [3:0]  frame_bytes,
	input  logic        frame_end,
	input  logic        result_valid,
	input  logic        kind,
	input  logic [31:0] result_seq,
	input  logic [63:0] delivered_data,
	input  logic [3:0]  delivered_bytes,
	input  logic        message_end,
	input  logic        last_of_run,
	output int          failures,
	output int          outstanding,
	output int          delivered_total,
	output int          acked_total,
	output logic [31:0] head_seq
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_COUNT = 16;
	localparam int CHUNK_BYTES = 8;
	localparam logic [63:0] CHUNK_MASK =
		(CHUNK_BYTES >= 8) ? '1 : ((64'd1 << (8 * CHUNK_BYTES)) - 64'd1);

	typedef struct packed {
		logic        kind;
		logic [31:0] seq;
		logic [63:0] data;
		logic [3:0]  nbytes;
		logic        msg_end;
		logic        last;
	} window_word_t;

	window_word_t awaited[$];

	logic [4:0]            cur_window;
	logic [31:0]           conn_start;
	logic [31:0]           expect_seq;
	logic [3:0]            head_idx;
	logic [SLOT_COUNT-1:0] slot_full;
	slot_entry_t           slot_mem [SLOT_COUNT];

	task restart_connection;
		expect_seq = conn_start;
		head_idx = '0;
		slot_full = '0;
	endtask

	task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endtask

	task match_word;
		window_word_t want;
		if (awaited.size() == 0) begin
			$error("Result word with nothing expected: kind %0h, seq %0h", kind, result_seq);
			failures++;
		end else begin
			want = awaited.pop_front();
			check_field("kind", 64'(want.kind), 64'(kind));
			check_field("result_seq", 64'(want.seq), 64'(result_seq));
			check_field("delivered_data", want.data, delivered_data);
			check_field("delivered_bytes", 64'(want.nbytes), 64'(delivered_bytes));
			check_field("message_end", 64'(want.msg_end), 64'(message_end));
			check_field("last_of_run", 64'(want.last), 64'(last_of_run));
		end
		if (kind === KIND_DELIVER)
			delivered_total++;
		else
			acked_total++;
	endtask

	task apply_reg;
		case (cfg_index)
			REG_WINDOW_SIZE: cur_window = cfg_data[4:0];
			REG_START_SEQ: begin
				conn_start = cfg_data;
				restart_connection();
			end
			default: begin
			end
		endcase
	endtask

	// Store the frame if it falls in the window, then drain the in-order run at
	// the head; the acknowledgement word always closes the frame.
	task absorb_frame(input logic [31:0] seq, input logic [63:0] data,
			input logic [3:0] nb, input logic fe);
		logic [31:0]  span;
		logic [31:0]  seq_delta;
		logic [3:0]   idx;
		window_word_t w;
		span = (cur_window > SLOT_COUNT) ? SLOT_COUNT : 32'(cur_window);
		seq_delta = seq - expect_seq;
		if (seq_delta < span) begin
			idx = head_idx + seq_delta[3:0];
			slot_full[idx] = 1'b1;
			slot_mem[idx].payload = data & CHUNK_MASK;
			slot_mem[idx].bytes = (nb > CHUNK_BYTES) ? 4'(CHUNK_BYTES) : nb;
			slot_mem[idx].end_flag = fe;
			while (slot_full[head_idx]) begin
				w.kind = KIND_DELIVER;
				w.seq = expect_seq;
				w.data = slot_mem[head_idx].payload;
				w.nbytes = slot_mem[head_idx].bytes;
				w.msg_end = slot_mem[head_idx].end_flag;
				w.last = 1'b0;
				awaited.push_back(w);
				slot_full[head_idx] = 1'b0;
				head_idx = head_idx + 4'd1;
				expect_seq = expect_seq + 32'd1;
			end
		end
		w.kind = KIND_ACK;
		w.seq = seq;
		w.data = '0;
		w.nbytes = '0;
		w.msg_end = 1'b0;
		w.last = 1'b1;
		awaited.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_window = WINDOW_SIZE_RESET;
			conn_start = '0;
			restart_connection();
			awaited.delete();
			failures = 0;
			delivered_total = 0;
			acked_total = 0;
		end else begin
			if (result_valid)
				match_word();
			if (cfg_wr)
				apply_reg();
			if (start && !busy)
				absorb_frame(frame_seq, frame_payload, frame_bytes, frame_end);
		end
		outstanding = awaited.size();
		head_seq = expect_seq;
	end

endmodule

>>> test/selective_repeat_receive_window_tb.sv
// Testbench top for the selective-repeat receive window: clock, reset, frame and
// register stimulus, and the verdict. Needs srrw_pkg, the block and srrw_window_checker.
module selective_repeat_receive_window_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import srrw_pkg::*;

	localparam int SLOT_COUNT = 16;
	localparam int RANDOM_FRAMES = 120;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        start;
	logic        busy;
	logic [31:0] frame_seq;
	logic [63:0] frame_payload;
	logic [3:0]  frame_bytes;
	logic        frame_end;
	logic        result_valid;
	logic        kind;
	logic [31:0] result_seq;
	logic [63:0] delivered_data;
	logic [3:0]  delivered_bytes;
	logic        message_end;
	logic        last_of_run;

	int          failures;
	int          outstanding;
	int          delivered_total;
	int          acked_total;
	logic [31:0] head_seq;

	int frames_sent = 0;
	int reg_writes = 0;
	int settings_used = 0;
	int span_now = SLOT_COUNT;
	int cycles = 0;
	bit steady = 1'b0;

	selective_repeat_receive_window u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr         (cfg_wr),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.frame_seq      (frame_seq),
		.frame_payload  (frame_payload),
		.frame_bytes    (frame_bytes),
		.frame_end      (frame_end),
		.result_valid   (result_valid),
		.kind           (kind),
		.result_seq     (result_seq),
		.delivered_data (delivered_data),
		.delivered_bytes(delivered_bytes),
		.message_end    (message_end),
		.last_of_run    (last_of_run)
	);

	srrw_window_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr         (cfg_wr),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.start          (start),
		.busy           (busy),
		.frame_seq      (frame_seq),
		.frame_payload  (frame_payload),
		.frame_bytes    (frame_bytes),
		.frame_end      (frame_end),
		.result_valid   (result_valid),
		.kind           (kind),
		.result_seq     (result_seq),
		.delivered_data (delivered_data),
		.delivered_bytes(delivered_bytes),
		.message_end    (message_end),
		.last_of_run    (last_of_run),
		.failures       (failures),
		.outstanding    (outstanding),
		.delivered_total(delivered_total),
		.acked_total    (acked_total),
		.head_seq       (head_seq)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task idle_sender;
		int gap;
		if (steady) begin
			gap = 0;
		end else begin
			case ($urandom_range(9, 0))
				0: gap = $urandom_range(40, 10);
				1, 2, 3: gap = $urandom_range(3, 1);
				default: gap = 0;
			endcase
		end
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task push_frame(input logic [31:0] seq, input logic [63:0] data,
			input logic [3:0] nb, input logic fe);
		@(negedge clk);
		start <= 1'b1;
		frame_seq <= seq;
		frame_payload <= data;
		frame_bytes <= nb;
		frame_end <= fe;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		frames_sent++;
		idle_sender();
	endtask

	task push_random(input logic [31:0] seq);
		logic [3:0] nb;
		nb = ($urandom_range(5, 0) == 0) ? 4'($urandom_range(15, 9)) :
			4'($urandom_range(8, 0));
		push_frame(seq, {$urandom, $urandom}, nb, 1'($urandom_range(1, 0)));
	endtask

	// Every frame ends in an acknowledgement word, so an empty expectation queue
	// means the block is idle.
	task settle;
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task write_reg(input logic idx, input logic [31:0] val);
		settle();
		cfg_wr <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr <= 1'b0;
		reg_writes++;
		if (idx == REG_WINDOW_SIZE)
			span_now = (val[4:0] > SLOT_COUNT) ? SLOT_COUNT : val[4:0];
	endtask

	// One burst of frames from the current head: a shuffled run, sometimes with a hole,
	// a repeated frame or a stray sequence number mixed in; zero window: three near it.
	task run_batch;
		logic [31:0] base;
		logic [31:0] tmp;
		logic [31:0] order[$];
		int k;
		int j;
		settle();
		base = head_seq;
		if (span_now == 0) begin
			repeat (3) push_random(base + $urandom_range(3, 0));
		end else begin
			k = ($urandom_range(3, 0) == 0) ? span_now : $urandom_range(span_now, 1);
			for (int i = 0; i < k; i++)
				order.push_back(base + i);
			for (int i = k - 1; i > 0; i--) begin
				j = $urandom_range(i, 0);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
			if ($urandom_range(4, 0) == 0)
				order.delete($urandom_range(order.size() - 1, 0));
			if ($urandom_range(4, 0) == 0 && order.size() > 0)
				order.push_back(order[$urandom_range(order.size() - 1, 0)]);
			if ($urandom_range(3, 0) == 0) begin
				case ($urandom_range(2, 0))
					0: tmp = base - $urandom_range(40, 1);
					1: tmp = base + span_now + $urandom_range(40, 0);
					default: tmp = $urandom;
				endcase
				if ($urandom_range(1, 0) == 0)
					order.push_front(tmp);
				else
					order.push_back(tmp);
			end
			foreach (order[i])
				push_random(order[i]);
		end
	endtask

	initial begin
		int directed_done;
		int phase_end;
		logic [31:0] val;
		arst_n = 1'b0;
		cfg_wr = 1'b0;
		cfg_index = REG_WINDOW_SIZE;
		cfg_data = '0;
		start = 1'b0;
		frame_seq = '0;
		frame_payload = '0;
		frame_bytes = '0;
		frame_end = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: full window from sequence zero.
		push_frame(32'd0, '1, 4'd8, 1'b1);
		push_frame(32'd2, '0, 4'd0, 1'b0);
		push_frame(32'd1, 64'h0123_4567_89AB_CDEF, 4'd15, 1'b1);
		push_frame(32'd18, {$urandom, $urandom}, 4'd9, 1'b0);
		push_frame(32'd19, {$urandom, $urandom}, 4'd8, 1'b1);
		push_frame(32'hFFFF_FFFF, '1, 4'd15, 1'b1);
		push_frame(32'd5, 64'hAAAA_AAAA_AAAA_AAAA, 4'd3, 1'b0);
		push_frame(32'd5, 64'h5555_5555_5555_5555, 4'd4, 1'b1);
		push_random(32'd4);
		for (int s = 6; s <= 17; s++)
			push_random(s);
		// Filling the head releases the whole window in one run.
		push_random(32'd3);

		write_reg(REG_WINDOW_SIZE, 32'd0);
		push_random(32'd19);
		write_reg(REG_WINDOW_SIZE, 32'hFFFF_FFFF);
		push_random(32'd21);
		// The frame held beyond a shrunken window must still come out.
		write_reg(REG_WINDOW_SIZE, 32'd1);
		push_random(32'd19);
		push_random(32'd20);

		write_reg(REG_WINDOW_SIZE, 32'd4);
		write_reg(REG_START_SEQ, 32'hFFFF_FFFE);
		push_random(32'hFFFF_FFFF);
		push_random(32'd1);
		push_random(32'd0);
		push_random(32'hFFFF_FFFE);
		directed_done = frames_sent;

		while (frames_sent - directed_done < RANDOM_FRAMES) begin
			val = $urandom;
			case ($urandom_range(7, 0))
				0: val[4:0] = 5'd0;
				1: val[4:0] = 5'd1;
				2: val[4:0] = 5'd2;
				3: val[4:0] = 5'd16;
				4: val[4:0] = 5'($urandom_range(31, 17));
				default: val[4:0] = 5'($urandom_range(15, 3));
			endcase
			write_reg(REG_WINDOW_SIZE, val);
			if ($urandom_range(2, 0) != 0) begin
				case ($urandom_range(3, 0))
					0: val = 32'd0;
					1: val = 32'hFFFF_FFFF;
					2: val = 32'hFFFF_FFF0 + $urandom_range(15, 0);
					default: val = $urandom;
				endcase
				write_reg(REG_START_SEQ, val);
			end
			steady = ($urandom_range(2, 0) == 0);
			phase_end = frames_sent + $urandom_range(30, 15);
			if (phase_end > directed_done + RANDOM_FRAMES)
				phase_end = directed_done + RANDOM_FRAMES;
			while (frames_sent < phase_end)
				run_batch();
			settings_used++;
		end

		settle();
		repeat (20) @(negedge clk);
		$display("Sent %0d frames over %0d random window settings, %0d register writes.",
			frames_sent, settings_used, reg_writes);
		$display("Saw %0d in-order words delivered and %0d frames acknowledged.",
			delivered_total, acked_total);
		if (failures == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
